>>> rtl/fvc_pkg.sv
// Package with the beat types, stage types and codes of the field value converter.
package fvc_pkg;

  typedef enum logic [2:0] {
    ENC_UNSIGNED = 3'd0,
    ENC_TWOS     = 3'd1,
    ENC_SIGNMAG  = 3'd2,
    ENC_BCD      = 3'd3,
    ENC_BCD2K    = 3'd4
  } enc_t;

  localparam logic ACT_TO_VALUE = 1'b0;
  localparam logic ACT_TO_RAW   = 1'b1;

  localparam logic [32:0] BCD_OFFSET = 33'd2000;

  typedef struct packed {
    logic        action;
    logic [2:0]  encoding;
    logic [5:0]  width;
    logic [31:0] data_in;
  } in_t;

  typedef struct packed {
    logic signed [31:0] value_out;
    logic [31:0]        raw_out;
    logic               in_range;
  } out_t;

  typedef struct packed {
    logic        sel_bcd;
    out_t        res;
    logic [30:0] d;
    logic [17:0] q0;
    logic [4:0]  h0;
  } mid_t;

  typedef struct packed {
    logic        sel_bcd;
    out_t        res;
    logic [13:0] lo4;
    logic [13:0] hi4;
  } dig_t;

endpackage

>>> rtl/fvc_front.sv
// Decoding, range checks and quotient estimates of the field value converter.
module fvc_front (
  input  fvc_pkg::in_t  item,
  output fvc_pkg::mid_t mid
);

  logic [5:0]  wc;
  logic [31:0] data;
  logic [31:0] mask;
  logic [31:0] sbit;
  logic [31:0] upper;
  logic [31:0] top_mask;
  logic [31:0] x;
  logic [31:0] absval;
  logic [27:0] bcd_sum;
  logic [32:0] d33;
  logic        ok_bcd;
  logic        ok_u;
  logic        ok_t;
  logic        ok_s;
  logic [49:0] prod_q;
  logic [36:0] prod_h;

  function automatic logic [7:0] bcd_pair(input logic [7:0] b);
    logic [7:0] hi;
    logic [7:0] lo;
    hi = {4'd0, b[7:4]};
    lo = {4'd0, b[3:0]};
    return (hi << 3) + (hi << 1) + lo;
  endfunction

  always_comb begin
    data = item.data_in;
    if (item.width == 6'd0) begin
      wc = 6'd1;
    end else if (item.width > 6'd32) begin
      wc = 6'd32;
    end else begin
      wc = item.width;
    end
    mask     = (wc == 6'd32) ? 32'hFFFF_FFFF : ((32'd1 << wc) - 32'd1);
    sbit     = 32'd1 << (wc - 6'd1);
    upper    = ~(sbit - 32'd1);
    top_mask = (wc == 6'd32) ? 32'h7FFF_FFFF : mask;
    x        = data & mask;
    absval   = data[31] ? (32'd0 - data) : data;
    bcd_sum  = {20'd0, bcd_pair(data[7:0])}
             + {20'd0, bcd_pair(data[15:8])} * 28'd100
             + {20'd0, bcd_pair(data[23:16])} * 28'd10000
             + {20'd0, bcd_pair(data[31:24])} * 28'd1000000;
    d33 = {data[31], data}
        - ((item.encoding == fvc_pkg::ENC_BCD2K) ? fvc_pkg::BCD_OFFSET : 33'd0);
    ok_bcd = !d33[32] && ((d33[31:0] & upper) == 32'd0);
    ok_u   = (data & ~top_mask) == 32'd0;
    ok_t   = ((data & upper) == 32'd0) || ((data & upper) == upper);
    ok_s   = (absval & upper) == 32'd0;
    prod_q = {23'd0, d33[30:4]} * 50'd6871947;
    prod_h = {14'd0, d33[30:8]} * 37'd10995;

    mid.sel_bcd       = 1'b0;
    mid.res.value_out = 32'sd0;
    mid.res.raw_out   = 32'd0;
    mid.res.in_range  = 1'b0;
    mid.d             = d33[30:0];
    mid.q0            = prod_q[49:32];
    mid.h0            = prod_h[36:32];

    if (item.action == fvc_pkg::ACT_TO_VALUE) begin
      case (item.encoding)
        fvc_pkg::ENC_UNSIGNED: mid.res.value_out = data;
        fvc_pkg::ENC_TWOS:     mid.res.value_out = (x ^ sbit) - sbit;
        fvc_pkg::ENC_SIGNMAG:
          mid.res.value_out = ((x & sbit) != 32'd0) ? (32'd0 - (x & ~sbit)) : x;
        fvc_pkg::ENC_BCD:      mid.res.value_out = {4'd0, bcd_sum};
        fvc_pkg::ENC_BCD2K:    mid.res.value_out = {4'd0, bcd_sum} + 32'd2000;
        default:               mid.res.value_out = 32'sd0;
      endcase
    end else begin
      case (item.encoding)
        fvc_pkg::ENC_UNSIGNED: begin
          mid.res.in_range = ok_u;
          mid.res.raw_out  = ok_u ? (data & mask) : 32'd0;
        end
        fvc_pkg::ENC_TWOS: begin
          mid.res.in_range = ok_t;
          mid.res.raw_out  = ok_t ? (data & mask) : 32'd0;
        end
        fvc_pkg::ENC_SIGNMAG: begin
          mid.res.in_range = ok_s;
          mid.res.raw_out  = ok_s ? (data[31] ? (sbit | absval) : data) : 32'd0;
        end
        fvc_pkg::ENC_BCD, fvc_pkg::ENC_BCD2K: begin
          mid.res.in_range = ok_bcd;
          mid.sel_bcd      = ok_bcd;
        end
        default: mid.res.in_range = 1'b0;
      endcase
    end
  end

endmodule

>>> rtl/fvc_split.sv
// Splits the BCD operand into its low and high groups of four decimal digits.
module fvc_split (
  input  fvc_pkg::mid_t mid,
  output fvc_pkg::dig_t dig
);

  logic [30:0] r1;
  logic [30:0] r2;
  logic        c1;
  logic        c2;
  logic [30:0] lo_full;
  logic [17:0] base;
  logic [17:0] hi_full;

  always_comb begin
    r1      = mid.d - {13'd0, mid.q0} * 31'd10000;
    c1      = r1 >= 31'd10000;
    lo_full = c1 ? (r1 - 31'd10000) : r1;
    r2      = mid.d - {26'd0, mid.h0} * 31'd100000000;
    c2      = r2 >= 31'd100000000;
    base    = mid.q0 - {13'd0, mid.h0} * 18'd10000;
    hi_full = base + {17'd0, c1} - (c2 ? 18'd10000 : 18'd0);

    dig.sel_bcd = mid.sel_bcd;
    dig.res     = mid.res;
    dig.lo4     = lo_full[13:0];
    dig.hi4     = hi_full[13:0];
  end

endmodule

>>> rtl/fvc_digits.sv
// Turns two four-digit groups into packed BCD and forms the result beat.
module fvc_digits (
  input  fvc_pkg::dig_t dig,
  output fvc_pkg::out_t res
);

  function automatic logic [7:0] pair_bcd(input logic [6:0] p);
    logic [13:0] prod;
    logic [3:0]  tens;
    logic [6:0]  ones;
    prod = {7'd0, p} * 14'd103;
    tens = prod[13:10];
    ones = p - {3'd0, tens} * 7'd10;
    return {tens, ones[3:0]};
  endfunction

  function automatic logic [15:0] group_bcd(input logic [13:0] v);
    logic [26:0] prod;
    logic [6:0]  hi;
    logic [13:0] lo;
    prod = {13'd0, v} * 27'd5243;
    hi   = prod[25:19];
    lo   = v - {7'd0, hi} * 14'd100;
    return {pair_bcd(hi), pair_bcd(lo[6:0])};
  endfunction

  always_comb begin
    res = dig.res;
    if (dig.sel_bcd) begin
      res.raw_out = {group_bcd(dig.hi4), group_bcd(dig.lo4)};
    end
  end

endmodule

>>> rtl/field_value_format_converter.sv
// Top level of the field value converter with its four-stage beat pipeline.
//
// Each input beat carries a direction, an encoding, a field width and a data
// word. The block turns a raw field word into an integer value, or an integer
// value into raw field bits with a range check, and returns one result beat
// for every input beat, in order.
// Both channels use valid and ready. An accepted beat passes the input,
// quotient, digit and output registers in turn before reaching out_valid.
// The pipeline takes one beat every cycle while out_ready is high; the
// longest path is the reciprocal multiply splitting BCD into decimal groups.
// Every stage has its own valid bit, so a new beat enters while finished
// results wait: when the receiver stalls, the stages fill up and in_ready
// falls only once all four registers hold a beat.
// Synchronous reset clears all stage valid bits; the block then accepts a beat
// as soon as reset is released. The data registers are not reset.
module field_value_format_converter (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  fvc_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_ready,
  output fvc_pkg::out_t out_data
);

  logic          s0_v_r;
  logic          s1_v_r;
  logic          s2_v_r;
  logic          s3_v_r;
  logic          s0_v_nxt;
  logic          s1_v_nxt;
  logic          s2_v_nxt;
  logic          s3_v_nxt;
  logic          rdy0;
  logic          rdy1;
  logic          rdy2;
  logic          rdy3;
  fvc_pkg::in_t  s0_r;
  fvc_pkg::mid_t s1_r;
  fvc_pkg::dig_t s2_r;
  fvc_pkg::out_t s3_r;
  fvc_pkg::mid_t s1_nxt;
  fvc_pkg::dig_t s2_nxt;
  fvc_pkg::out_t s3_nxt;

  fvc_front u_front (
    .item (s0_r),
    .mid  (s1_nxt)
  );

  fvc_split u_split (
    .mid (s1_r),
    .dig (s2_nxt)
  );

  fvc_digits u_digits (
    .dig (s2_r),
    .res (s3_nxt)
  );

  always_comb begin
    rdy3     = !s3_v_r || out_ready;
    rdy2     = !s2_v_r || rdy3;
    rdy1     = !s1_v_r || rdy2;
    rdy0     = !s0_v_r || rdy1;
    s0_v_nxt = rdy0 ? in_valid : s0_v_r;
    s1_v_nxt = rdy1 ? s0_v_r : s1_v_r;
    s2_v_nxt = rdy2 ? s1_v_r : s2_v_r;
    s3_v_nxt = rdy3 ? s2_v_r : s3_v_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_v_r <= 1'b0;
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
      s3_v_r <= 1'b0;
    end else begin
      s0_v_r <= s0_v_nxt;
      s1_v_r <= s1_v_nxt;
      s2_v_r <= s2_v_nxt;
      s3_v_r <= s3_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy0) begin
      s0_r <= in_data;
    end
    if (rdy1) begin
      s1_r <= s1_nxt;
    end
    if (rdy2) begin
      s2_r <= s2_nxt;
    end
    if (rdy3) begin
      s3_r <= s3_nxt;
    end
  end

  assign in_ready  = rdy0;
  assign out_valid = s3_v_r;
  assign out_data  = s3_r;

endmodule

>>> dv/field_value_format_converter_tb.sv
// Self-checking testbench for the field value converter with a queue-fed driver and a monitor.
`timescale 1ns / 100ps

module field_value_format_converter_tb;

  localparam int RANDOM_ITEMS = 600;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES = 8;
  localparam logic [2:0] ENC_RESERVED_MIN = 3'd5;
  localparam logic [2:0] ENC_RESERVED_MAX = 3'd7;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  fvc_pkg::in_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  fvc_pkg::out_t out_data;

  fvc_pkg::in_t queued_requests[$];
  fvc_pkg::out_t predicted_results[$];
  int error_count = 0;
  int quiet_cycles = 0;
  int burst_left = 0;
  int gap_left = 0;
  int ready_mode = 0;
  int mode_left = 0;
  int total_items = 0;
  int results_seen = 0;

  field_value_format_converter u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  always #4 clk = ~clk;

  function automatic fvc_pkg::out_t convert_field(fvc_pkg::in_t item);
    fvc_pkg::out_t res;
    int unsigned w;
    int unsigned top;
    int i;
    logic [31:0] mask;
    logic [31:0] sbit;
    logic [31:0] x;
    logic [31:0] bcd_sum;
    logic [31:0] weight;
    logic [31:0] pair_val;
    logic [31:0] rest;
    longint v;
    longint half;
    longint d;
    logic fits;
    res = '0;
    fits = 1'b0;
    w = item.width;
    if (w == 0) w = 1;
    if (w > 32) w = 32;
    mask = (w == 32) ? 32'hFFFF_FFFF : ((32'd1 << w) - 32'd1);
    sbit = 32'd1 << (w - 1);
    x = item.data_in & mask;
    bcd_sum = 32'd0;
    weight = 32'd1;
    for (i = 0; i < 4; i++) begin
      bcd_sum = bcd_sum + weight *
                (item.data_in[8*i+4 +: 4] * 32'd10 + item.data_in[8*i +: 4]);
      weight = weight * 32'd100;
    end
    v = $signed(item.data_in);
    half = {32'd0, sbit};
    if (item.action == fvc_pkg::ACT_TO_VALUE) begin
      case (item.encoding)
        fvc_pkg::ENC_UNSIGNED: res.value_out = item.data_in;
        fvc_pkg::ENC_TWOS:     res.value_out = (x ^ sbit) - sbit;
        fvc_pkg::ENC_SIGNMAG:
          res.value_out = ((x & sbit) != 0) ? 32'd0 - (x & ~sbit) : x;
        fvc_pkg::ENC_BCD:      res.value_out = bcd_sum;
        fvc_pkg::ENC_BCD2K:    res.value_out = bcd_sum + fvc_pkg::BCD_OFFSET[31:0];
        default:               res.value_out = 32'd0;
      endcase
    end else begin
      case (item.encoding)
        fvc_pkg::ENC_UNSIGNED: begin
          top = (w == 32) ? 31 : w;
          fits = (v >= 0) && (v <= (longint'(1) << top) - 1);
          res.raw_out = v[31:0] & mask;
        end
        fvc_pkg::ENC_TWOS: begin
          fits = (v >= -half) && (v <= half - 1);
          res.raw_out = v[31:0] & mask;
        end
        fvc_pkg::ENC_SIGNMAG: begin
          fits = (v >= -(half - 1)) && (v <= half - 1);
          d = -v;
          res.raw_out = (v < 0) ? (sbit | d[31:0]) : v[31:0];
        end
        fvc_pkg::ENC_BCD, fvc_pkg::ENC_BCD2K: begin
          d = v - ((item.encoding == fvc_pkg::ENC_BCD2K) ?
                   longint'(fvc_pkg::BCD_OFFSET) : longint'(0));
          fits = (d >= 0) && (d <= half - 1);
          rest = d[31:0];
          res.raw_out = 32'd0;
          for (i = 0; i < 4; i++) begin
            pair_val = rest % 32'd100;
            res.raw_out = res.raw_out |
                          (((pair_val / 32'd10) * 32'd16 + pair_val % 32'd10) << (8 * i));
            rest = rest / 32'd100;
          end
        end
        default: fits = 1'b0;
      endcase
      if (!fits) res.raw_out = 32'd0;
      res.in_range = fits;
    end
    return res;
  endfunction

  function automatic void add_request(logic act, logic [2:0] enc, logic [5:0] wd,
                                      logic [31:0] data);
    fvc_pkg::in_t item;
    item.action = act;
    item.encoding = enc;
    item.width = wd;
    item.data_in = data;
    queued_requests.push_back(item);
  endfunction

  always @(posedge clk) begin
    if (rst_n) begin
      if (!in_valid || in_ready) begin
        if (in_valid) predicted_results.push_back(convert_field(in_data));
        if (burst_left == 0) begin
          gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
          burst_left <= $urandom_range(1, 40);
          in_valid <= 1'b0;
        end else if (gap_left > 0) begin
          gap_left <= gap_left - 1;
          in_valid <= 1'b0;
        end else if (queued_requests.size() != 0) begin
          in_data <= queued_requests.pop_front();
          in_valid <= 1'b1;
          burst_left <= burst_left - 1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    fvc_pkg::out_t want;
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (out_valid && out_ready) begin
        results_seen++;
        if (predicted_results.size() == 0) begin
          $error("Result beat arrived with no prediction pending.");
          error_count++;
        end else begin
          want = predicted_results.pop_front();
          if (out_data.value_out !== want.value_out) begin
            $error("value_out: expected %0d, actual %0d", want.value_out, out_data.value_out);
            error_count++;
          end
          if (out_data.raw_out !== want.raw_out) begin
            $error("raw_out: expected %h, actual %h", want.raw_out, out_data.raw_out);
            error_count++;
          end
          if (out_data.in_range !== want.in_range) begin
            $error("in_range: expected %0b, actual %0b", want.in_range, out_data.in_range);
            error_count++;
          end
        end
      end
      if (mode_left == 0) begin
        ready_mode <= $urandom_range(0, 2);
        mode_left <= $urandom_range(20, 200);
      end else begin
        mode_left <= mode_left - 1;
      end
      case (ready_mode)
        0: out_ready <= 1'b1;
        1: out_ready <= ($urandom_range(0, 3) != 0);
        default: out_ready <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  initial begin
    fvc_pkg::in_t item;
    int n;
    int i;
    int pick;
    int kind;
    int unsigned wv;
    longint half;
    longint val;
    logic timed_out;
    timed_out = 1'b0;

    add_request(fvc_pkg::ACT_TO_VALUE, fvc_pkg::ENC_UNSIGNED, 6'd1, 32'hFFFF_FFFF);
    add_request(fvc_pkg::ACT_TO_VALUE, fvc_pkg::ENC_TWOS, 6'd32, 32'h8000_0000);
    add_request(fvc_pkg::ACT_TO_VALUE, fvc_pkg::ENC_TWOS, 6'd1, 32'h0000_0001);
    add_request(fvc_pkg::ACT_TO_VALUE, fvc_pkg::ENC_TWOS, 6'd8, 32'hFFFF_FF80);
    add_request(fvc_pkg::ACT_TO_VALUE, fvc_pkg::ENC_SIGNMAG, 6'd8, 32'h0000_0080);
    add_request(fvc_pkg::ACT_TO_VALUE, fvc_pkg::ENC_SIGNMAG, 6'd8, 32'h0000_00FF);
    add_request(fvc_pkg::ACT_TO_VALUE, fvc_pkg::ENC_SIGNMAG, 6'd32, 32'h8000_0001);
    add_request(fvc_pkg::ACT_TO_VALUE, fvc_pkg::ENC_BCD, 6'd4, 32'h9999_9999);
    add_request(fvc_pkg::ACT_TO_VALUE, fvc_pkg::ENC_BCD, 6'd32, 32'hFFFF_FFFF);
    add_request(fvc_pkg::ACT_TO_VALUE, fvc_pkg::ENC_BCD2K, 6'd16, 32'h1234_5678);
    add_request(fvc_pkg::ACT_TO_RAW, fvc_pkg::ENC_UNSIGNED, 6'd32, 32'h7FFF_FFFF);
    add_request(fvc_pkg::ACT_TO_RAW, fvc_pkg::ENC_UNSIGNED, 6'd32, 32'h8000_0000);
    add_request(fvc_pkg::ACT_TO_RAW, fvc_pkg::ENC_UNSIGNED, 6'd4, 32'd15);
    add_request(fvc_pkg::ACT_TO_RAW, fvc_pkg::ENC_UNSIGNED, 6'd4, 32'd16);
    add_request(fvc_pkg::ACT_TO_RAW, fvc_pkg::ENC_TWOS, 6'd32, 32'h8000_0000);
    add_request(fvc_pkg::ACT_TO_RAW, fvc_pkg::ENC_TWOS, 6'd4, 32'hFFFF_FFF8);
    add_request(fvc_pkg::ACT_TO_RAW, fvc_pkg::ENC_TWOS, 6'd4, 32'hFFFF_FFF7);
    add_request(fvc_pkg::ACT_TO_RAW, fvc_pkg::ENC_SIGNMAG, 6'd4, 32'hFFFF_FFF9);
    add_request(fvc_pkg::ACT_TO_RAW, fvc_pkg::ENC_SIGNMAG, 6'd4, 32'hFFFF_FFF8);
    add_request(fvc_pkg::ACT_TO_RAW, fvc_pkg::ENC_SIGNMAG, 6'd1, 32'd0);
    add_request(fvc_pkg::ACT_TO_RAW, fvc_pkg::ENC_BCD, 6'd32, 32'h7FFF_FFFF);
    add_request(fvc_pkg::ACT_TO_RAW, fvc_pkg::ENC_BCD, 6'd32, 32'hFFFF_FFFF);
    add_request(fvc_pkg::ACT_TO_RAW, fvc_pkg::ENC_BCD2K, 6'd12, 32'd1999);
    add_request(fvc_pkg::ACT_TO_RAW, fvc_pkg::ENC_BCD2K, 6'd12, 32'd2000);
    add_request(fvc_pkg::ACT_TO_RAW, fvc_pkg::ENC_BCD2K, 6'd32, 32'h8000_0000);
    add_request(fvc_pkg::ACT_TO_VALUE, fvc_pkg::ENC_TWOS, 6'd0, 32'h0000_0001);
    add_request(fvc_pkg::ACT_TO_RAW, fvc_pkg::ENC_UNSIGNED, 6'd63, 32'h7FFF_FFFF);
    add_request(fvc_pkg::ACT_TO_VALUE, ENC_RESERVED_MIN, 6'd8, 32'h1234_5678);
    add_request(fvc_pkg::ACT_TO_RAW, ENC_RESERVED_MAX, 6'd8, 32'd5);

    for (n = 0; n < RANDOM_ITEMS; n++) begin
      item.action = 1'($urandom_range(0, 1));
      item.encoding = ($urandom_range(0, 19) == 0) ?
                      3'($urandom_range(ENC_RESERVED_MIN, ENC_RESERVED_MAX)) :
                      3'($urandom_range(fvc_pkg::ENC_UNSIGNED, fvc_pkg::ENC_BCD2K));
      pick = $urandom_range(0, 19);
      if (pick == 0) item.width = 6'd0;
      else if (pick == 1) item.width = 6'($urandom_range(33, 63));
      else if (pick < 5) item.width = 6'd32;
      else item.width = 6'($urandom_range(1, 32));
      wv = (item.width == 0) ? 1 : (item.width > 32) ? 32 : item.width;
      half = longint'(1) << (wv - 1);
      kind = $urandom_range(0, 3);
      if (kind == 0) begin
        item.data_in = $urandom();
      end else if (item.action == fvc_pkg::ACT_TO_VALUE) begin
        if (kind == 1) begin
          for (i = 0; i < 8; i++) item.data_in[4*i +: 4] = 4'($urandom_range(0, 9));
        end else if (kind == 2) begin
          item.data_in = $urandom() >> $urandom_range(0, 31);
        end else begin
          val = half;
          item.data_in = $urandom_range(0, 1) ? val[31:0] : ($urandom() | val[31:0]);
        end
      end else begin
        if (kind == 3) begin
          val = longint'($signed($urandom())) >>> $urandom_range(0, 31);
        end else begin
          case ($urandom_range(0, 5))
            0: val = 0;
            1: val = half;
            2: val = half * 2;
            3: val = -half;
            4: val = longint'(fvc_pkg::BCD_OFFSET);
            default: val = longint'(fvc_pkg::BCD_OFFSET) + half;
          endcase
          val = val + $urandom_range(0, 6) - 3;
        end
        item.data_in = val[31:0];
      end
      queued_requests.push_back(item);
    end
    total_items = queued_requests.size();

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    while (results_seen < total_items && quiet_cycles < WATCHDOG_LIMIT)
      @(posedge clk);
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      timed_out = 1'b1;
    end else begin
      repeat (DRAIN_CYCLES) @(posedge clk);
      if (predicted_results.size() != 0) begin
        $error("%0d predicted results never arrived.", predicted_results.size());
        error_count++;
      end
    end

    if (!timed_out && error_count == 0) $display("Test completed successfully");
    else $display("Test completed with failures");
    $finish;
  end

endmodule

>>> files.f
rtl/fvc_pkg.sv
rtl/fvc_front.sv
rtl/fvc_split.sv
rtl/fvc_digits.sv
rtl/field_value_format_converter.sv
dv/field_value_format_converter_tb.sv
